@@ hw/rtl/dwc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwc_pkg: shared types and constants for the deque with cursor
// Ring geometry, operation and status codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package dwc_pkg;

  // Ring geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT    = 3'd0,
    OP_PUSH_RIGHT   = 3'd1,
    OP_POP_LEFT     = 3'd2,
    OP_POP_RIGHT    = 3'd3,
    OP_CURSOR_LEFT  = 3'd4,
    OP_CURSOR_RIGHT = 3'd5,
    OP_WRITE_CURSOR = 3'd6,
    OP_QUERY        = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_END   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_ENDS,
    S_RD_CUR,
    S_DONE
  } state_e;

  // Which address the first store read port looks at; the second always reads the right end
  typedef enum logic [1:0] {
    RD_POP,
    RD_ENDS,
    RD_CUR
  } rd_sel_e;

  typedef struct packed {
    logic    load;      // latch the incoming beat
    logic    exec;      // apply the operation to pointers and store
    logic    cap_pop;   // capture the popped word
    logic    cap_ends;  // capture the end words
    logic    finish;    // load the result register
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;     // result register can take a new beat
  } sts_t;

  // Ring slot at a given offset from the head
  function automatic logic [IDX_W-1:0] slot(logic [IDX_W-1:0] head,
                                            logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/dwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dwc_ctrl: sequencer for the deque with cursor
// Steps each accepted beat through execute, two read phases and the
// hand-over to the result register.
// ----------------------------------------------------------------------------
module dwc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dwc_pkg::sts_t sts_i,
  output dwc_pkg::cmd_t cmd_o
);

  dwc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.cap_pop   = 1'b0;
    cmd_o.cap_ends  = 1'b0;
    cmd_o.finish    = 1'b0;
    cmd_o.rd_sel    = dwc_pkg::RD_POP;
    in_stall_o      = 1'b1;
    case (state_q)
      dwc_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dwc_pkg::S_EXEC;
        end
      end
      dwc_pkg::S_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.rd_sel = dwc_pkg::RD_POP;
        state_d      = dwc_pkg::S_RD_ENDS;
      end
      dwc_pkg::S_RD_ENDS: begin
        cmd_o.cap_pop = 1'b1;
        cmd_o.rd_sel  = dwc_pkg::RD_ENDS;
        state_d       = dwc_pkg::S_RD_CUR;
      end
      dwc_pkg::S_RD_CUR: begin
        cmd_o.cap_ends = 1'b1;
        cmd_o.rd_sel   = dwc_pkg::RD_CUR;
        state_d        = dwc_pkg::S_DONE;
      end
      dwc_pkg::S_DONE: begin
        // keep the cursor address so the read data holds while we wait
        cmd_o.rd_sel = dwc_pkg::RD_CUR;
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = dwc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dwc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/dwc_dp.sv @@
// ----------------------------------------------------------------------------
// dwc_dp: datapath for the deque with cursor
// Ring store, head/fill/cursor pointers, operation decode and the result
// register on the output side.
// ----------------------------------------------------------------------------
module dwc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dwc_pkg::cmd_t                      cmd_i,
  output dwc_pkg::sts_t                      sts_o,
  input  logic        [dwc_pkg::OP_W-1:0]    op_i,
  input  logic signed [dwc_pkg::WORD_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [dwc_pkg::STAT_W-1:0]  status_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  popped_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  left_word_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  right_word_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  cursor_word_o,
  output logic        [dwc_pkg::OCC_W-1:0]   occupancy_o
);

  localparam int unsigned IW = dwc_pkg::IDX_W;
  localparam int unsigned CW = dwc_pkg::CNT_W;
  localparam int unsigned WW = dwc_pkg::WORD_W;

  // Latched beat
  dwc_pkg::op_e  op_q;
  logic [WW-1:0] value_q;

  // Pointers
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] cur_q, cur_d;

  // Execute-phase results
  dwc_pkg::status_e status_c, status_q;
  logic             we_c;
  logic [IW-1:0]    waddr_c;
  logic [CW-1:0]    fill_m1;
  logic             is_pop_q;

  // Store
  logic [WW-1:0] mem [dwc_pkg::DEPTH];
  logic [IW-1:0] raddr_a, raddr_b;
  logic [WW-1:0] rd_a_q, rd_b_q;

  // Captured words
  logic [WW-1:0] popped_q, left_q, right_q;

  // Result register
  logic                     out_valid_q;
  logic [dwc_pkg::STAT_W-1:0] st_out_q;
  logic [WW-1:0]            popped_out_q, left_out_q, right_out_q, cursor_out_q;
  logic [dwc_pkg::OCC_W-1:0] occ_out_q;

  assign fill_m1 = fill_q - CW'(1);

  // Latch the beat on acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= dwc_pkg::op_e'(op_i);
      value_q <= value_i;
    end
  end

  // Operation decode: status, store write and next pointers
  always_comb begin
    status_c = dwc_pkg::STAT_OK;
    we_c     = 1'b0;
    waddr_c  = head_q;
    head_d   = head_q;
    fill_d   = fill_q;
    cur_d    = cur_q;
    case (op_q)
      dwc_pkg::OP_PUSH_LEFT: begin
        if (fill_q >= CW'(dwc_pkg::DEPTH)) begin
          status_c = dwc_pkg::STAT_FULL;
        end else begin
          head_d  = (head_q == '0) ? IW'(dwc_pkg::DEPTH - 1) : head_q - IW'(1);
          we_c    = 1'b1;
          waddr_c = head_d;
          cur_d   = (fill_q == '0) ? '0 : cur_q + IW'(1);
          fill_d  = fill_q + CW'(1);
        end
      end
      dwc_pkg::OP_PUSH_RIGHT: begin
        if (fill_q >= CW'(dwc_pkg::DEPTH)) begin
          status_c = dwc_pkg::STAT_FULL;
        end else begin
          we_c    = 1'b1;
          waddr_c = dwc_pkg::slot(head_q, fill_q[IW-1:0]);
          cur_d   = (fill_q == '0) ? '0 : cur_q;
          fill_d  = fill_q + CW'(1);
        end
      end
      dwc_pkg::OP_POP_LEFT: begin
        if (fill_q == '0) begin
          status_c = dwc_pkg::STAT_EMPTY;
        end else begin
          cur_d  = (cur_q != '0 && fill_m1 != '0) ? cur_q - IW'(1) : '0;
          head_d = (head_q == IW'(dwc_pkg::DEPTH - 1)) ? '0 : head_q + IW'(1);
          fill_d = fill_m1;
        end
      end
      dwc_pkg::OP_POP_RIGHT: begin
        if (fill_q == '0) begin
          status_c = dwc_pkg::STAT_EMPTY;
        end else begin
          fill_d = fill_m1;
          if (fill_m1 == '0) begin
            cur_d = '0;
          end else if (CW'(cur_q) >= fill_m1) begin
            cur_d = IW'(fill_m1 - CW'(1));
          end
        end
      end
      dwc_pkg::OP_CURSOR_LEFT: begin
        if (fill_q == '0) begin
          status_c = dwc_pkg::STAT_EMPTY;
        end else if (cur_q == '0) begin
          status_c = dwc_pkg::STAT_END;
        end else begin
          cur_d = cur_q - IW'(1);
        end
      end
      dwc_pkg::OP_CURSOR_RIGHT: begin
        if (fill_q == '0) begin
          status_c = dwc_pkg::STAT_EMPTY;
        end else if (CW'(cur_q) + CW'(1) >= fill_q) begin
          status_c = dwc_pkg::STAT_END;
        end else begin
          cur_d = cur_q + IW'(1);
        end
      end
      dwc_pkg::OP_WRITE_CURSOR: begin
        if (fill_q == '0) begin
          status_c = dwc_pkg::STAT_EMPTY;
        end else begin
          we_c    = 1'b1;
          waddr_c = dwc_pkg::slot(head_q, cur_q);
        end
      end
      default: begin
        // query: nothing changes
      end
    endcase
  end

  // Pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      cur_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      fill_q <= fill_d;
      cur_q  <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_c;
      is_pop_q <= op_q inside {dwc_pkg::OP_POP_LEFT, dwc_pkg::OP_POP_RIGHT};
    end
  end

  // Read address selection; pop reads see the pointers before update
  always_comb begin
    raddr_a = head_q;
    raddr_b = dwc_pkg::slot(head_q, fill_m1[IW-1:0]);
    case (cmd_i.rd_sel)
      dwc_pkg::RD_POP: begin
        raddr_a = (op_q == dwc_pkg::OP_POP_LEFT) ? head_q
                                                 : dwc_pkg::slot(head_q, fill_m1[IW-1:0]);
      end
      dwc_pkg::RD_ENDS: begin
        raddr_a = head_q;
      end
      dwc_pkg::RD_CUR: begin
        raddr_a = dwc_pkg::slot(head_q, cur_q);
      end
      default: begin
        raddr_a = head_q;
      end
    endcase
  end

  // Ring store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we_c) begin
      mem[waddr_c] <= value_q;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  // Capture popped and end words
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pop) begin
      popped_q <= (is_pop_q && status_q == dwc_pkg::STAT_OK) ? rd_a_q : '0;
    end
    if (cmd_i.cap_ends) begin
      left_q  <= rd_a_q;
      right_q <= rd_b_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      st_out_q     <= status_q;
      popped_out_q <= popped_q;
      left_out_q   <= (fill_q == '0) ? '0 : left_q;
      right_out_q  <= (fill_q == '0) ? '0 : right_q;
      cursor_out_q <= (fill_q == '0) ? '0 : rd_a_q;
      occ_out_q    <= dwc_pkg::OCC_W'(fill_q);
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = st_out_q;
  assign popped_o      = popped_out_q;
  assign left_word_o   = left_out_q;
  assign right_word_o  = right_out_q;
  assign cursor_word_o = cursor_out_q;
  assign occupancy_o   = occ_out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(dwc_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_cur_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (cur_q == '0))
    else $error("cursor off origin on empty deque");

  a_cur_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> (CW'(cur_q) < fill_q))
    else $error("cursor outside the held words");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> ($stable(fill_q) && $stable(head_q) && $stable(cur_q)))
    else $error("pointers moved outside execute");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

@@ hw/rtl/deque_with_cursor.sv @@
// ----------------------------------------------------------------------------
// deque_with_cursor: bounded double-ended queue with a cursor
// A beat steps through execute, two read phases and the hand-over to
// the result register; the input stalls until then, as its four store
// reads (popped, both ends, cursor) go through a two-port registered-read ring.
// Reset: asynchronous, active low; empties the deque, store contents kept.
// The result register lets a finished beat wait while the next is accepted.
// ----------------------------------------------------------------------------
module deque_with_cursor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic        [dwc_pkg::OP_W-1:0]    op_i,
  input  logic signed [dwc_pkg::WORD_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [dwc_pkg::STAT_W-1:0]  status_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  popped_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  left_word_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  right_word_o,
  output logic signed [dwc_pkg::WORD_W-1:0]  cursor_word_o,
  output logic        [dwc_pkg::OCC_W-1:0]   occupancy_o
);

  dwc_pkg::cmd_t cmd;
  dwc_pkg::sts_t sts;

  // Sequencer
  dwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store, pointers and result register
  dwc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_o      (popped_o),
    .left_word_o   (left_word_o),
    .right_word_o  (right_word_o),
    .cursor_word_o (cursor_word_o),
    .occupancy_o   (occupancy_o)
  );

endmodule
